### rtl/mocd_pkg.sv
// shared constants, types and tables for the multi-output clock divider
package mocd_pkg;

    localparam int GATE_COUNT     = 4;
    localparam int TICKS_PER_BEAT = 128;
    localparam int TPB_LOG2       = $clog2(TICKS_PER_BEAT);
    localparam int MAX_DIVISOR    = 512;

    localparam int ELAPSED_W = 30;
    localparam int BEAT_W    = 37;
    localparam int SETUP_W   = 48;
    localparam int ACC_W     = 40;
    localparam int TIMER_W   = 35;
    localparam int POS_W     = 19;
    localparam int DIV_W     = 10;
    localparam int RIDX_W    = 4;
    localparam int GATE_W    = 34;
    localparam int RES_W     = 11;
    localparam int MOD_W     = 20;
    localparam int CNT_W     = $clog2(POS_W + 1);
    localparam int IDX_W     = $clog2(GATE_COUNT);
    localparam int CFG_IDX_W = 3;
    localparam int PERIOD_W  = BEAT_W - TPB_LOG2;

    // setup word layout
    localparam int DIV_LSB  = 0;
    localparam int RIDX_LSB = DIV_LSB + DIV_W;
    localparam int GATE_LSB = RIDX_LSB + RIDX_W;

    localparam logic [BEAT_W-1:0]  BEAT_RESET  = BEAT_W'(500000000);
    localparam logic [SETUP_W-1:0] SETUP_RESET = SETUP_W'(3073);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BEAT_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT0     = 3'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_TICK,
        S_SETUP,
        S_MOD,
        S_GATE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic             latch;
        logic             acc_add;
        logic             acc_tick;
        logic             mod_start;
        logic             gate_upd;
        logic             out_load;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic fired_now;
        logic mod_busy;
        logic out_free;
    } t_sts;

    // ticks per step for each resolution index, out-of-range index takes the finest
    function automatic logic [RES_W-1:0] res_lookup(input logic [RIDX_W-1:0] ridx);
        logic [RES_W-1:0] res;
        case (ridx)
            4'd0:    res = RES_W'(TICKS_PER_BEAT * 8);
            4'd1:    res = RES_W'(TICKS_PER_BEAT * 4);
            4'd2:    res = RES_W'(TICKS_PER_BEAT * 2);
            4'd3:    res = RES_W'(TICKS_PER_BEAT);
            4'd4:    res = RES_W'(TICKS_PER_BEAT / 3);
            4'd5:    res = RES_W'(TICKS_PER_BEAT / 2);
            4'd6:    res = RES_W'(TICKS_PER_BEAT / 6);
            4'd7:    res = RES_W'(TICKS_PER_BEAT / 4);
            4'd8:    res = RES_W'(TICKS_PER_BEAT / 12);
            4'd9:    res = RES_W'(TICKS_PER_BEAT / 8);
            4'd10:   res = RES_W'(TICKS_PER_BEAT / 24);
            4'd11:   res = RES_W'(TICKS_PER_BEAT / 16);
            4'd12:   res = RES_W'(TICKS_PER_BEAT / 48);
            4'd13:   res = RES_W'(TICKS_PER_BEAT / 32);
            default: res = RES_W'(TICKS_PER_BEAT / 96);
        endcase
        if (res == '0) begin
            res = RES_W'(1);
        end
        return res;
    endfunction

endpackage

### rtl/multi_output_clock_divider.sv
// top level of the multi-output clock divider with gates
//
//  channel  dir  handshake                 payload
//  -------  ---  ------------------------  -----------------------------------------
//  input    in   i_in_valid / o_in_stall   i_elapsed[29:0], i_reset_level
//  output   out  o_out_valid / i_out_stall o_gate_0..3, o_tick_fired, o_clock_position
//  config   in   i_cfg_we                  i_cfg_index[2:0], i_cfg_data[47:0]
//
//  a word without tick or reset restart passes latch, add, tick test and load in turn
//  a tick or restart adds setup, remainder and gate steps for each output in turn, on the
//  one-bit-per-cycle remainder unit shared by the four outputs
//  i_rst_n is synchronous, active low: state cleared, registers back to defaults
//  the next word is taken while a result still sits in the output register
//  a stalled output holds the finished word; the block waits before loading the next one
module multi_output_clock_divider
    import mocd_pkg::*;
#(
    parameter logic [BEAT_W-1:0]  BEAT_INIT  = BEAT_RESET,
    parameter logic [SETUP_W-1:0] SETUP_INIT = SETUP_RESET
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // config write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SETUP_W-1:0]   i_cfg_data,

    // input words
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [ELAPSED_W-1:0] i_elapsed,
    input  logic                 i_reset_level,

    // result words
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_gate_0,
    output logic                 o_gate_1,
    output logic                 o_gate_2,
    output logic                 o_gate_3,
    output logic                 o_tick_fired,
    output logic [POS_W-1:0]     o_clock_position
);

    t_cmd                   w_cmd;
    t_sts                   w_sts;
    logic [GATE_COUNT-1:0]  w_gates;

    // state machine: one word at a time, walks the outputs on a tick or reset restart
    mocd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    // accumulator, position, gate timers and the output register
    mocd_dp #(
        .BEAT_INIT  (BEAT_INIT),
        .SETUP_INIT (SETUP_INIT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_elapsed        (i_elapsed),
        .i_reset_level    (i_reset_level),
        .i_out_stall      (i_out_stall),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_out_valid      (o_out_valid),
        .o_gates          (w_gates),
        .o_tick_fired     (o_tick_fired),
        .o_clock_position (o_clock_position)
    );

    // one gate port per output
    assign o_gate_0 = w_gates[0];
    assign o_gate_1 = w_gates[1];
    assign o_gate_2 = w_gates[2];
    assign o_gate_3 = w_gates[3];

endmodule

### rtl/mocd_rem.sv
// bit-serial remainder unit: position modulo the output modulus
module mocd_rem
    import mocd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [POS_W-1:0] i_dividend,
    input  logic [MOD_W-1:0] i_modulus,
    output logic             o_busy,
    output logic             o_zero
);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [MOD_W-1:0] r_rem;
    logic [MOD_W-1:0] r_mod;
    logic [POS_W-1:0] r_dvd;
    logic [MOD_W:0]   n_trial;
    logic             n_ge;

    assign n_trial = {r_rem, r_dvd[POS_W-1]};
    assign n_ge    = n_trial >= {1'b0, r_mod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(POS_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_mod <= i_modulus;
            r_dvd <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_ge ? MOD_W'(n_trial - {1'b0, r_mod}) : MOD_W'(n_trial);
            r_dvd <= {r_dvd[POS_W-2:0], 1'b0};
        end
    end

    assign o_busy = r_busy;
    assign o_zero = (r_rem == '0);

`ifndef NO_ASSERTIONS
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("remainder started while busy");
`endif

endmodule

### rtl/mocd_dp.sv
// datapath: config registers, accumulator, position, gate timers, output register
module mocd_dp
    import mocd_pkg::*;
#(
    parameter logic [BEAT_W-1:0]  BEAT_INIT  = BEAT_RESET,
    parameter logic [SETUP_W-1:0] SETUP_INIT = SETUP_RESET
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SETUP_W-1:0]   i_cfg_data,
    input  logic [ELAPSED_W-1:0] i_elapsed,
    input  logic                 i_reset_level,
    input  logic                 i_out_stall,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    output logic                 o_out_valid,
    output logic [GATE_COUNT-1:0] o_gates,
    output logic                 o_tick_fired,
    output logic [POS_W-1:0]     o_clock_position
);

    logic [BEAT_W-1:0]    r_beat;
    logic [SETUP_W-1:0]   r_setup [GATE_COUNT];
    logic [ELAPSED_W-1:0] r_dt;
    logic                 r_level;
    logic [ACC_W-1:0]     r_acc;
    logic [POS_W-1:0]     r_pos;
    logic [TIMER_W-1:0]   r_timer [GATE_COUNT];
    logic [GATE_COUNT-1:0] r_held;
    logic                 r_prev;
    logic                 r_fired;
    logic                 r_o_valid;
    logic [GATE_COUNT-1:0] r_o_gates;
    logic                 r_o_tick;
    logic [POS_W-1:0]     r_o_pos;

    logic [ACC_W:0]       n_sum;
    logic [ACC_W-1:0]     n_acc_sat;
    logic [ACC_W-1:0]     n_period;
    logic                 n_tick;
    logic                 n_rising;
    logic [SETUP_W-1:0]   n_setup;
    logic [DIV_W-1:0]     n_div;
    logic [RES_W-1:0]     n_res;
    logic [DIV_W+RES_W-1:0] n_prod;
    logic                 n_rem_zero;
    logic                 n_mod_busy;
    logic [TIMER_W-1:0]   n_tsel;
    logic [TIMER_W:0]     n_tsum;
    logic [TIMER_W-1:0]   n_tnew;
    logic                 n_pass;

    // saturating accumulate and tick test
    assign n_sum     = {1'b0, r_acc} + (ACC_W+1)'(r_dt);
    assign n_acc_sat = n_sum[ACC_W] ? '1 : n_sum[ACC_W-1:0];
    assign n_period  = ACC_W'(r_beat[BEAT_W-1:TPB_LOG2]);
    assign n_tick    = r_acc >= n_period;
    assign n_rising  = r_level && !r_prev;

    // modulus for the selected output
    always_comb begin
        n_setup = r_setup[i_cmd.idx];
        n_div   = n_setup[DIV_LSB +: DIV_W];
        if (n_div == '0) begin
            n_div = DIV_W'(1);
        end else if (n_div > DIV_W'(MAX_DIVISOR)) begin
            n_div = DIV_W'(MAX_DIVISOR);
        end
        n_res  = res_lookup(n_setup[RIDX_LSB +: RIDX_W]);
        n_prod = (DIV_W+RES_W)'(n_div) * (DIV_W+RES_W)'(n_res);
    end

    mocd_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mod_start),
        .i_dividend (r_pos),
        .i_modulus  (n_prod[MOD_W-1:0]),
        .o_busy     (n_mod_busy),
        .o_zero     (n_rem_zero)
    );

    // gate timer step
    always_comb begin
        n_tsel = n_rem_zero ? '0 : r_timer[i_cmd.idx];
        n_pass = n_tsel <= TIMER_W'(n_setup[GATE_LSB +: GATE_W]);
        n_tsum = {1'b0, n_tsel} + (TIMER_W+1)'(r_dt);
        n_tnew = n_tsum[TIMER_W] ? '1 : n_tsum[TIMER_W-1:0];
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat <= BEAT_INIT;
            for (int i = 0; i < GATE_COUNT; i++) begin
                r_setup[i] <= SETUP_INIT;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_BEAT_PERIOD) begin
                r_beat <= i_cfg_data[BEAT_W-1:0];
            end
            for (int i = 0; i < GATE_COUNT; i++) begin
                if (i_cfg_index == CFG_OUTPUT0 + CFG_IDX_W'(i)) begin
                    r_setup[i] <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_dt    <= i_elapsed;
            r_level <= i_reset_level;
        end
    end

    // clock state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_pos   <= '0;
            r_prev  <= 1'b0;
            r_fired <= 1'b0;
            r_held  <= '0;
            for (int i = 0; i < GATE_COUNT; i++) begin
                r_timer[i] <= '0;
            end
        end else begin
            if (i_cmd.acc_add) begin
                r_acc <= n_acc_sat;
            end
            if (i_cmd.acc_tick) begin
                r_fired <= n_tick || n_rising;
                if (n_tick) begin
                    r_acc <= r_acc - n_period;
                    r_pos <= r_pos + POS_W'(1);
                end else begin
                    r_prev <= r_level;
                    if (n_rising) begin
                        r_acc <= '0;
                        r_pos <= '0;
                        for (int i = 0; i < GATE_COUNT; i++) begin
                            r_timer[i] <= '0;
                        end
                    end
                end
            end
            if (i_cmd.gate_upd) begin
                r_held[i_cmd.idx] <= n_pass;
                r_timer[i_cmd.idx] <= n_pass ? n_tnew : n_tsel;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_gates <= r_held;
            r_o_tick  <= r_fired;
            r_o_pos   <= r_pos;
        end
    end

    assign o_sts.fired_now  = n_tick || n_rising;
    assign o_sts.mod_busy   = n_mod_busy;
    assign o_sts.out_free   = !r_o_valid || !i_out_stall;
    assign o_out_valid      = r_o_valid;
    assign o_gates          = r_o_gates;
    assign o_tick_fired     = r_o_tick;
    assign o_clock_position = r_o_pos;

`ifndef NO_ASSERTIONS
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_o_valid || !i_out_stall))
        else $error("result loaded over a waiting word");

    a_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.acc_tick |=> $stable(r_pos))
        else $error("position moved outside the tick step");
`endif

endmodule

### rtl/mocd_ctrl.sv
// controller: sequences accumulate, tick test and the per-output gate steps
module mocd_ctrl
    import mocd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_stall,
    output t_cmd o_cmd
);

    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                n_state = S_TICK;
            end
            S_TICK: begin
                n_idx   = '0;
                n_state = i_sts.fired_now ? S_SETUP : S_OUT;
            end
            S_SETUP: begin
                n_state = S_MOD;
            end
            S_MOD: begin
                if (!i_sts.mod_busy) begin
                    n_state = S_GATE;
                end
            end
            S_GATE: begin
                if (r_idx == IDX_W'(GATE_COUNT - 1)) begin
                    n_state = S_OUT;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_SETUP;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_cmd.idx  = r_idx;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.latch = i_in_valid;
            end
            S_SUM:   o_cmd.acc_add   = 1'b1;
            S_TICK:  o_cmd.acc_tick  = 1'b1;
            S_SETUP: o_cmd.mod_start = 1'b1;
            S_MOD:   o_cmd.latch     = 1'b0;
            S_GATE:  o_cmd.gate_upd  = 1'b1;
            S_OUT:   o_cmd.out_load  = i_sts.out_free;
            default: o_in_stall      = 1'b1;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_accept_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_SUM))
        else $error("accepted word not followed by accumulate");

    a_gate_after_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GATE) |-> !i_sts.mod_busy)
        else $error("gate step while remainder still running");
`endif

endmodule
